// ===== hdl/hds_pkg.sv =====
package hds_pkg;

  // data word and fixed-point layout
  localparam int WORD_W = 32;
  localparam int FRAC_W = 16;
  localparam int STEP_W = 16;
  localparam int NCFG_W = 6;
  localparam int IDX_W  = 6;
  localparam int CFG_ADDR_W = 8;

  // diffusion gain 0.3 as a Q0.16 numerator
  localparam int GAIN_NUM = 19661;

  // internal arithmetic widths: laplacian, product, update sum
  localparam int LAP_W  = WORD_W + 3;
  localparam int PROD_W = LAP_W + 16;
  localparam int SUM_W  = WORD_W + 4;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_INTERIOR_CELLS = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_START_TEMP     = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LEFT_TEMP      = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_TEMP     = 8'd3;

  localparam logic [NCFG_W-1:0] INTERIOR_CELLS_RST = 6'd62;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic load;   // take the initial rod value
    logic mul;    // register laplacian times gain
    logic upd;    // add the scaled laplacian and saturate
    logic shift;  // move one word toward cell 0
  } hds_ctrl_t;

endpackage

// ===== hdl/hds_cell.sv =====
module hds_cell (
  input  logic                             clk,
  input  hds_pkg::hds_ctrl_t               ctrl,
  input  logic                             interior,
  input  logic signed [hds_pkg::WORD_W-1:0] load_value,
  input  logic signed [hds_pkg::WORD_W-1:0] left_value,
  input  logic signed [hds_pkg::WORD_W-1:0] right_value,
  output logic signed [hds_pkg::WORD_W-1:0] value
);
  import hds_pkg::*;

  localparam logic signed [PROD_W-1:0] GAIN = PROD_W'(GAIN_NUM);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sd2147483648);

  logic signed [LAP_W-1:0]          lap;
  logic signed [PROD_W-1:0]         prod;
  logic signed [PROD_W-1:0]         prod_next;
  logic signed [PROD_W-FRAC_W-1:0]  delta;
  logic signed [SUM_W-1:0]          sum;
  logic signed [WORD_W-1:0]         value_next;

  // three-point laplacian and gain product
  always_comb begin
    lap = LAP_W'(left_value) - (LAP_W'(value) <<< 1) + LAP_W'(right_value);
    prod_next = PROD_W'(lap) * GAIN;
  end

  // floor shift, add, saturate
  always_comb begin
    delta = $signed(prod[PROD_W-1:FRAC_W]);
    sum = SUM_W'(value) + SUM_W'(delta);
    if (sum > SAT_HI) begin
      value_next = SAT_HI[WORD_W-1:0];
    end else if (sum < SAT_LO) begin
      value_next = SAT_LO[WORD_W-1:0];
    end else begin
      value_next = sum[WORD_W-1:0];
    end
  end

  // cell storage
  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod <= prod_next;
    end
    if (ctrl.load) begin
      value <= load_value;
    end else if (ctrl.shift) begin
      value <= right_value;
    end else if (ctrl.upd && interior) begin
      value <= value_next;
    end
  end

endmodule

// ===== hdl/heat_diffusion_stencil_1d_top.sv =====
// One-dimensional heat equation solver, explicit three-point scheme in signed
// Q16.16. Each accepted step_count word builds a rod of interior_cells + 2
// cells (left_temp, start_temp repeated, right_temp; interior_cells above
// MAX_CELLS-2 is clamped), runs step_count steps of u += 0.3*(l - 2u + r)
// with floor rounding and 32-bit saturation, and then streams out every cell
// from the left boundary to the right one, last marking the right boundary.
// The rod lives in a row of MAX_CELLS cells that all update in parallel; each
// time step is a gain multiply (MUL) and then an add and saturate (UPD), and
// after the last step the row streams out one word per cycle (n + 2 words)
// while out_stall is low. One run is in flight at a time; in_stall is high
// from acceptance until the last word is taken. The user is to write the
// configuration (cfg_ready always high) between runs; it is not enforced.
module heat_diffusion_stencil_1d_top #(
  parameter int MAX_CELLS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [hds_pkg::CFG_ADDR_W-1:0]        cfg_index,
  input  logic [hds_pkg::WORD_W-1:0]            cfg_data,
  // run request
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [hds_pkg::STEP_W-1:0]            step_count,
  // cell stream
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [hds_pkg::IDX_W-1:0]             cell_index,
  output logic signed [hds_pkg::WORD_W-1:0]     temperature,
  output logic                                  last
);
  import hds_pkg::*;

  localparam int CW = $clog2(MAX_CELLS);
  localparam logic [NCFG_W:0] N_MAX = (NCFG_W+1)'(MAX_CELLS - 2);

  typedef enum logic [2:0] {
    IDLE,
    MUL,
    UPD,
    EMIT
  } state_t;

  state_t state;

  logic [NCFG_W-1:0]        interior_cells;
  logic signed [WORD_W-1:0] start_temp;
  logic signed [WORD_W-1:0] left_temp;
  logic signed [WORD_W-1:0] right_temp;

  logic [CW-1:0]     n_run;
  logic [CW-1:0]     n_next;
  logic [STEP_W-1:0] steps_left;
  logic [CW-1:0]     out_idx;

  logic in_accept;
  logic out_accept;
  hds_ctrl_t ctrl;

  logic signed [WORD_W-1:0] cell_val [MAX_CELLS];

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      interior_cells <= INTERIOR_CELLS_RST;
      start_temp     <= '0;
      left_temp      <= '0;
      right_temp     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_INTERIOR_CELLS: interior_cells <= cfg_data[NCFG_W-1:0];
        REG_START_TEMP:     start_temp     <= cfg_data;
        REG_LEFT_TEMP:      left_temp      <= cfg_data;
        REG_RIGHT_TEMP:     right_temp     <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp interior count to the row length
  always_comb begin
    if ({1'b0, interior_cells} > N_MAX) begin
      n_next = N_MAX[CW-1:0];
    end else begin
      n_next = CW'(interior_cells);
    end
  end

  // handshakes
  assign in_stall   = (state != IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_valid  = (state == EMIT);
  assign out_accept = out_valid && !out_stall;

  // cell control broadcast
  always_comb begin
    ctrl.load  = in_accept;
    ctrl.mul   = (state == MUL);
    ctrl.upd   = (state == UPD);
    ctrl.shift = out_accept;
  end

  // run sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      n_run      <= '0;
      steps_left <= '0;
      out_idx    <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_accept) begin
            n_run      <= n_next;
            steps_left <= step_count;
            out_idx    <= '0;
            state      <= (step_count == '0) ? EMIT : MUL;
          end
        end
        MUL: begin
          state <= UPD;
        end
        UPD: begin
          steps_left <= steps_left - 1'b1;
          state      <= (steps_left == STEP_W'(1)) ? EMIT : MUL;
        end
        EMIT: begin
          if (out_accept) begin
            out_idx <= out_idx + 1'b1;
            if (out_idx == n_run + 1'b1) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // row of cells
  for (genvar i = 0; i < MAX_CELLS; i++) begin : g_cell
    logic                     interior;
    logic signed [WORD_W-1:0] load_value;
    logic signed [WORD_W-1:0] left_value;
    logic signed [WORD_W-1:0] right_value;

    always_comb begin
      interior = (i != 0) && (CW'(i) <= n_run);
      if (i == 0) begin
        load_value = left_temp;
      end else if (CW'(i) <= n_next) begin
        load_value = start_temp;
      end else begin
        load_value = right_temp;
      end
    end

    if (i == 0) begin : g_first
      assign left_value = cell_val[i];
    end else begin : g_inner_l
      assign left_value = cell_val[i-1];
    end

    if (i == MAX_CELLS - 1) begin : g_final
      assign right_value = cell_val[i];
    end else begin : g_inner_r
      assign right_value = cell_val[i+1];
    end

    hds_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .interior    (interior),
      .load_value  (load_value),
      .left_value  (left_value),
      .right_value (right_value),
      .value       (cell_val[i])
    );
  end

  // output word comes from the head of the row
  assign cell_index  = IDX_W'(out_idx);
  assign temperature = cell_val[0];
  assign last        = (out_idx == n_run + 1'b1);

endmodule

// ===== bench/heat_diffusion_stencil_1d_top_test.sv =====
module heat_diffusion_stencil_1d_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hds_pkg::*;

  // one output word of the cell stream
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] temp;
    logic              last;
  } cell_word_t;

  // one row of the directed plan: rod setup, step count, optional typed answer
  typedef struct packed {
    logic [WORD_W-1:0] cells_word;
    logic [WORD_W-1:0] start_t;
    logic [WORD_W-1:0] left_t;
    logic [WORD_W-1:0] right_t;
    logic [STEP_W-1:0] steps;
    logic              typed;
    logic [WORD_W-1:0] flat_t;
  } rod_case_t;

  localparam int ROD_CELLS = 64;
  localparam int PLAN_ROWS = 19;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_index;
  logic [WORD_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [STEP_W-1:0] step_count;
  logic out_valid;
  logic out_stall;
  logic [IDX_W-1:0] cell_index;
  logic signed [WORD_W-1:0] temperature;
  logic last;

  // register copies as the block should hold them
  logic [NCFG_W-1:0] cells_reg;
  logic [WORD_W-1:0] start_reg;
  logic [WORD_W-1:0] left_reg;
  logic [WORD_W-1:0] right_reg;

  cell_word_t rod_cells_due[$];
  rod_case_t plan[PLAN_ROWS];
  int mismatches = 0;
  int words_taken = 0;

  heat_diffusion_stencil_1d_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .step_count  (step_count),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cell_index  (cell_index),
    .temperature (temperature),
    .last        (last)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $realtime, what);
    mismatches++;
  endtask

  // interior cell count after clamping to the rod length
  function automatic int live_cells();
    return (cells_reg > ROD_CELLS - 2) ? ROD_CELLS - 2 : int'(cells_reg);
  endfunction

  // one explicit update: u + floor(gain * (l - 2u + r) / 2^16), saturated
  function automatic int relax_cell(input int l, input int c, input int r);
    longint lap;
    longint v;
    lap = longint'(l) - 2 * longint'(c) + longint'(r);
    v = longint'(c) + ((lap * longint'(GAIN_NUM)) >>> FRAC_W);
    if (v > 64'sh0000_0000_7FFF_FFFF) v = 64'sh0000_0000_7FFF_FFFF;
    if (v < -64'sh0000_0000_8000_0000) v = -64'sh0000_0000_8000_0000;
    return int'(v);
  endfunction

  // queue one word per cell of the rod
  function automatic void queue_rod(input int rod[ROD_CELLS], input int n);
    cell_word_t w;
    for (int i = 0; i <= n + 1; i++) begin
      w.idx = IDX_W'(i);
      w.temp = rod[i];
      w.last = (i == n + 1);
      rod_cells_due.push_back(w);
    end
  endfunction

  // build the rod, run the time steps, queue the final cells
  function automatic void diffuse_rod(input logic [STEP_W-1:0] steps);
    int n;
    int rod[ROD_CELLS];
    int upd[ROD_CELLS];
    n = live_cells();
    rod[0] = left_reg;
    for (int i = 1; i <= n; i++) rod[i] = start_reg;
    rod[n + 1] = right_reg;
    for (int k = 0; k < int'(steps); k++) begin
      for (int i = 1; i <= n; i++) upd[i] = relax_cell(rod[i - 1], rod[i], rod[i + 1]);
      for (int i = 1; i <= n; i++) rod[i] = upd[i];
    end
    queue_rod(rod, n);
  endfunction

  // rod whose interior is known without stepping
  function automatic void flat_rod(input logic [WORD_W-1:0] flat_t);
    int n;
    int rod[ROD_CELLS];
    n = live_cells();
    rod[0] = left_reg;
    for (int i = 1; i <= n; i++) rod[i] = flat_t;
    rod[n + 1] = right_reg;
    queue_rod(rod, n);
  endfunction

  // check every word taken from the cell stream
  always @(posedge clk) begin : check_cells
    cell_word_t want;
    if (!rst && out_valid && !out_stall) begin
      words_taken++;
      if (rod_cells_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word cell %0d temp %h last %b",
                                  cell_index, temperature, last));
      end else begin
        want = rod_cells_due.pop_front();
        if (cell_index !== want.idx)
          report_mismatch($sformatf("cell_index %0d, want %0d", cell_index, want.idx));
        if (temperature !== want.temp)
          report_mismatch($sformatf("cell %0d temperature %h, want %h",
                                    want.idx, temperature, want.temp));
        if (last !== want.last)
          report_mismatch($sformatf("cell %0d last %b, want %b", want.idx, last, want.last));
      end
    end
  end

  // receiver stalls: short and long holds, calm stretches, one long hold-off
  initial begin : out_side
    int hold_left;
    int calm_left;
    int r;
    bit pressed;
    hold_left = 0;
    calm_left = 0;
    pressed = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressed && words_taken >= 200 && in_valid && in_stall && out_valid) begin
        pressed = 1'b1;
        hold_left = 600;
      end else if (hold_left == 0) begin
        if (calm_left > 0) begin
          calm_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 3) calm_left = $urandom_range(100, 400);
          else if (r < 20) hold_left = $urandom_range(1, 3);
          else if (r < 22) hold_left = $urandom_range(10, 40);
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // sender gap before the next run request
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [WORD_W-1:0] pick_temp();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000;
    endcase
  endfunction

  // interior count, sometimes with junk in the upper bits
  function automatic logic [WORD_W-1:0] pick_cells();
    logic [WORD_W-1:0] n;
    n = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 12) : $urandom_range(13, 63);
    if ($urandom_range(0, 1)) n = n | ($urandom & 32'hFFFF_FFC0);
    return n;
  endfunction

  function automatic logic [STEP_W-1:0] pick_steps(input int item);
    if (item == 25 || item == 75) return STEP_W'($urandom_range(8192, 65535));
    if ($urandom_range(0, 99) < 75) return STEP_W'($urandom_range(0, 30));
    return STEP_W'($urandom_range(31, 600));
  endfunction

  // hold the request side until every expected word is in
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(negedge clk); while (rod_cells_due.size() != 0);
  endtask

  // one register write; the caller lowers cfg_valid after the batch
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_INTERIOR_CELLS: cells_reg = data[NCFG_W-1:0];
      REG_START_TEMP:     start_reg = data;
      REG_LEFT_TEMP:      left_reg = data;
      REG_RIGHT_TEMP:     right_reg = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // reprogram the rod while the block is idle, plus a write to a bad index
  task automatic set_rod(input logic [WORD_W-1:0] cells_word, input logic [WORD_W-1:0] start_t,
                         input logic [WORD_W-1:0] left_t, input logic [WORD_W-1:0] right_t);
    wait_quiet();
    write_reg(REG_INTERIOR_CELLS, cells_word);
    write_reg(REG_START_TEMP, start_t);
    write_reg(REG_LEFT_TEMP, left_t);
    write_reg(REG_RIGHT_TEMP, right_t);
    write_reg(CFG_ADDR_W'($urandom_range(REG_RIGHT_TEMP + 1, 255)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  // offer one run request and queue its cells once taken
  task automatic offer_run(input logic [STEP_W-1:0] steps, input int gap, input logic typed,
                           input logic [WORD_W-1:0] flat_t);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    step_count <= steps;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (typed) flat_rod(flat_t);
    else diffuse_rod(steps);
    @(negedge clk);
  endtask

  initial begin : stimulus
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    step_count = '0;
    cells_reg = INTERIOR_CELLS_RST;
    start_reg = '0;
    left_reg = '0;
    right_reg = '0;

    // cells, start, left, right, steps, typed, interior value when typed
    plan = '{
      '{32'd62, 32'h0, 32'h0, 32'h0, 16'd1, 1'b1, 32'h0},
      '{32'd62, 32'h0, 32'h0, 32'h0, 16'd0, 1'b1, 32'h0},
      '{32'd5, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'd100, 1'b1, 32'h0001_0000},
      '{32'd5, 32'h0003_0000, 32'h0, 32'h0005_0000, 16'd0, 1'b1, 32'h0003_0000},
      '{32'd5, 32'h0003_0000, 32'h0, 32'h0005_0000, 16'd1, 1'b0, 32'h0},
      '{32'd5, 32'h0003_0000, 32'h0, 32'h0005_0000, 16'd7, 1'b0, 32'h0},
      '{32'd0, 32'h1234_5678, 32'h7FFF_FFFF, 32'h8000_0000, 16'd3, 1'b1, 32'h0},
      '{32'd0, 32'h1234_5678, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 1'b1, 32'h0},
      '{32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd1, 1'b0, 32'h0},
      '{32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd2, 1'b0, 32'h0},
      '{32'd62, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd40, 1'b0, 32'h0},
      '{32'd63, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'd5, 1'b0, 32'h0},
      '{32'hFFFF_FFC3, 32'hFFFF_0000, 32'h0, 32'h0064_0000, 16'd2, 1'b0, 32'h0},
      '{32'hFFFF_FFC3, 32'hFFFF_0000, 32'h0, 32'h0064_0000, 16'd65535, 1'b0, 32'h0},
      '{32'd10, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd300, 1'b1, 32'h7FFF_FFFF},
      '{32'd10, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'd300, 1'b1, 32'h8000_0000},
      '{32'd2, 32'h1, 32'h0, 32'h0, 16'd1, 1'b0, 32'h0},
      '{32'd2, 32'hFFFF_FFFF, 32'h0, 32'h0, 16'd3, 1'b0, 32'h0},
      '{32'd62, 32'h0, 32'h0064_0000, 32'hFF9C_0000, 16'd1000, 1'b0, 32'h0}
    };

    // synchronous reset, released at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows, reprogramming only where the rod changes
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].cells_word[NCFG_W-1:0] != cells_reg || plan[r].start_t != start_reg ||
          plan[r].left_t != left_reg || plan[r].right_t != right_reg) begin
        set_rod(plan[r].cells_word, plan[r].start_t, plan[r].left_t, plan[r].right_t);
      end
      offer_run(plan[r].steps, pick_gap(), plan[r].typed, plan[r].flat_t);
    end

    // random runs with a new rod every dozen requests
    for (int item = 0; item < 100; item++) begin
      if (item % 12 == 0) set_rod(pick_cells(), pick_temp(), pick_temp(), pick_temp());
      else if (item == 54) wait_quiet();
      offer_run(pick_steps(item), pick_gap(), 1'b0, '0);
    end

    // drain, then watch a while for stray words
    wait_quiet();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
